// ===== rtl/upk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package upk_pkg;

    localparam int unsigned CHUNK_TZ    = 10;
    localparam int unsigned CHUNK_ODD   = 7;
    localparam int unsigned CHUNK_BYTES = CHUNK_ODD << CHUNK_TZ;

    // 2**ODD_DIGIT is 1 modulo CHUNK_ODD, so digit sums keep the residue
    localparam int unsigned ODD_DIGIT   = 3;

    localparam int unsigned SIZE_W      = 32;
    localparam int unsigned OFS_W       = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned SUM_W       = 16;
    localparam int unsigned ADDR_W      = 4;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned BEAT_W      = 4;

    localparam int unsigned FOLD_DIGITS = (SIZE_W - CHUNK_TZ + ODD_DIGIT - 1) / ODD_DIGIT;
    localparam int unsigned FOLD_W      = FOLD_DIGITS * ODD_DIGIT;

    localparam logic [OFS_W-1:0]  CHUNK_LEN     = OFS_W'(CHUNK_BYTES);
    localparam logic [BYTE_W-1:0] SYNC_0        = 8'hB7;
    localparam logic [BYTE_W-1:0] SYNC_1        = 8'hA1;
    localparam logic [BYTE_W-1:0] HDR_PAD       = 8'h00;
    localparam logic [BYTE_W:0]   FLETCHER_MOD  = 9'd255;
    localparam logic [BEAT_W-1:0] BEAT_FIRST    = 4'd0;
    localparam logic [BEAT_W-1:0] BEAT_FINAL    = 4'd8;

    localparam logic [BYTE_W-1:0] START_RESET   = 8'd2;
    localparam logic [BYTE_W-1:0] TYPE_RESET    = 8'd129;
    localparam logic [SIZE_W-1:0] SIZE_RESET    = 32'd1;

    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_TYPE  = 2'd1;
    localparam logic [1:0] REG_SIZE  = 2'd2;

    typedef enum logic [2:0] {
        POS_START,
        POS_SYNC0,
        POS_SYNC1,
        POS_TYPE,
        POS_PAD,
        POS_NUM,
        POS_LEN_HI,
        POS_LEN_LO
    } hdr_pos_t;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] packet_type;
        logic [SIZE_W-1:0] image_size;
        logic              trail_ok;
    } cfg_t;

    typedef struct packed {
        logic              lead;
        logic              trail;
        logic [BYTE_W-1:0] lead_num;
        logic [BYTE_W-1:0] trail_num;
        logic [OFS_W-1:0]  lead_len;
        logic [BYTE_W-1:0] data;
        logic              eop;
        logic              last;
        logic [SUM_W-1:0]  sum;
    } job_t;

    function automatic logic [BYTE_W-1:0] header_byte(
        input hdr_pos_t          pos,
        input cfg_t              cfg,
        input logic [BYTE_W-1:0] num,
        input logic [OFS_W-1:0]  len
    );
        logic [BYTE_W-1:0] b;
        case (pos)
            POS_START:  b = cfg.start_byte;
            POS_SYNC0:  b = SYNC_0;
            POS_SYNC1:  b = SYNC_1;
            POS_TYPE:   b = cfg.packet_type;
            POS_PAD:    b = HDR_PAD;
            POS_NUM:    b = num;
            POS_LEN_HI: b = len[OFS_W-1:BYTE_W];
            POS_LEN_LO: b = len[BYTE_W-1:0];
            default:    b = HDR_PAD;
        endcase
        return b;
    endfunction

    // size is a multiple of the chunk, zero included: low bits clear, odd part by digit sum
    function automatic logic chunk_multiple(input logic [SIZE_W-1:0] size);
        logic [FOLD_W-1:0] q;
        logic [5:0]        f1;
        logic [3:0]        f2;
        logic [3:0]        f3;
        q  = FOLD_W'(size >> CHUNK_TZ);
        f1 = '0;
        for (int i = 0; i < FOLD_DIGITS; i++) begin
            f1 = f1 + 6'(q[i*ODD_DIGIT +: ODD_DIGIT]);
        end
        f2 = 4'(f1[2:0]) + 4'(f1[5:3]);
        f3 = 4'(f2[2:0]) + 4'(f2[3]);
        return (size[CHUNK_TZ-1:0] == '0) && ((f3 == 4'd0) || (f3 == 4'(CHUNK_ODD)));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/update_image_packetizer.sv =====
// channel   | handshake              | payload
// ----------+------------------------+----------------------------------------------
// s_        | s_valid / s_ready      | s_image_byte
// m_        | m_valid / m_ready      | m_out_byte, m_is_header, m_end_of_packet,
//           |                        | m_last_of_run, m_image_checksum, m_checksum_valid
// apb       | psel/penable/pready    | paddr, pwrite, pwdata, prdata
//
// the output register sends one beat per cycle while m_ready allows; a byte inside a packet is one beat
// a byte that opens a packet, or closes an image with a trailing empty header, is nine beats
// a job register holds the current byte's results; the next byte is taken as its last beat loads
// sustained rate, while m_ready stays high, is one byte per cycle apart from the eight header beats per packet
// aresetn is synchronous; it clears the counters and sums and sets the registers to defaults
`timescale 1ns / 1ps
`default_nettype none

module update_image_packetizer (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [upk_pkg::ADDR_W-1:0] paddr,
    input  wire logic [upk_pkg::DATA_W-1:0] pwdata,
    output logic      [upk_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [upk_pkg::BYTE_W-1:0] s_image_byte,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [upk_pkg::BYTE_W-1:0]      m_out_byte,
    output logic                            m_is_header,
    output logic                            m_end_of_packet,
    output logic                            m_last_of_run,
    output logic [upk_pkg::SUM_W-1:0]       m_image_checksum,
    output logic                            m_checksum_valid
);
    import upk_pkg::*;

    cfg_t cfg;
    job_t job;
    logic job_valid;
    logic job_take;

    upk_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    upk_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_image_byte (s_image_byte),
        .cfg          (cfg),
        .job          (job),
        .job_valid    (job_valid),
        .job_take     (job_take)
    );

    upk_emit u_emit (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .job              (job),
        .job_valid        (job_valid),
        .job_take         (job_take),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_is_header      (m_is_header),
        .m_end_of_packet  (m_end_of_packet),
        .m_last_of_run    (m_last_of_run),
        .m_image_checksum (m_image_checksum),
        .m_checksum_valid (m_checksum_valid)
    );

endmodule

`default_nettype wire

// ===== rtl/upk_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module upk_regs (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [upk_pkg::ADDR_W-1:0] paddr,
    input  wire logic [upk_pkg::DATA_W-1:0] pwdata,
    output logic      [upk_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output upk_pkg::cfg_t                   cfg
);
    import upk_pkg::*;

    logic [BYTE_W-1:0] start_reg;
    logic [BYTE_W-1:0] type_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              trail_ok_reg;
    logic              wr;
    logic [1:0]        idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg    <= START_RESET;
            type_reg     <= TYPE_RESET;
            size_reg     <= SIZE_RESET;
            trail_ok_reg <= 1'b0;
        end else if (wr) begin
            case (idx)
                REG_START: start_reg <= pwdata[BYTE_W-1:0];
                REG_TYPE:  type_reg  <= pwdata[BYTE_W-1:0];
                REG_SIZE: begin
                    size_reg     <= pwdata[SIZE_W-1:0];
                    trail_ok_reg <= chunk_multiple(pwdata[SIZE_W-1:0])
                                    && (pwdata[SIZE_W-1:0] > SIZE_W'(CHUNK_BYTES));
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_START: prdata = DATA_W'(start_reg);
            REG_TYPE:  prdata = DATA_W'(type_reg);
            REG_SIZE:  prdata = DATA_W'(size_reg);
            default:   prdata = '0;
        endcase
    end

    assign cfg.start_byte  = start_reg;
    assign cfg.packet_type = type_reg;
    assign cfg.image_size  = size_reg;
    assign cfg.trail_ok    = trail_ok_reg;

endmodule

`default_nettype wire

// ===== rtl/upk_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module upk_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [upk_pkg::BYTE_W-1:0] s_image_byte,
    input  wire upk_pkg::cfg_t              cfg,
    output upk_pkg::job_t                   job,
    output logic                            job_valid,
    input  wire logic                       job_take
);
    import upk_pkg::*;

    logic [SIZE_W-1:0] taken_reg;
    logic [BYTE_W-1:0] num_reg;
    logic [OFS_W-1:0]  ofs_reg;
    logic [BYTE_W-1:0] low_reg;
    logic [BYTE_W-1:0] high_reg;
    job_t              job_reg;
    logic              job_valid_reg;

    logic              accept;
    logic [SIZE_W-1:0] size_eff;
    logic [SIZE_W:0]   taken_inc;
    logic [OFS_W:0]    ofs_inc;
    logic [SIZE_W-1:0] remaining;
    logic [OFS_W-1:0]  len;
    logic              last;
    logic              opened;
    logic              eop;
    logic [BYTE_W:0]   s1_raw;
    logic [BYTE_W:0]   s2_raw;
    logic [BYTE_W-1:0] s1;
    logic [BYTE_W-1:0] s2;
    job_t              job_next;

    assign s_ready = !job_valid_reg || job_take;
    assign accept  = s_valid && s_ready;

    always_comb begin
        size_eff  = (cfg.image_size == '0) ? SIZE_RESET : cfg.image_size;
        taken_inc = {1'b0, taken_reg} + (SIZE_W+1)'(1);
        last      = taken_inc >= {1'b0, size_eff};
        opened    = ofs_reg == '0;
        remaining = (size_eff > taken_reg) ? size_eff - taken_reg : SIZE_RESET;
        len       = (remaining < SIZE_W'(CHUNK_BYTES)) ? remaining[OFS_W-1:0] : CHUNK_LEN;
        ofs_inc   = {1'b0, ofs_reg} + (OFS_W+1)'(1);
        eop       = last || (ofs_inc >= (OFS_W+1)'(CHUNK_BYTES));

        s1_raw = {1'b0, low_reg} + {1'b0, s_image_byte};
        s1     = (s1_raw >= FLETCHER_MOD) ? BYTE_W'(s1_raw - FLETCHER_MOD) : s1_raw[BYTE_W-1:0];
        s2_raw = {1'b0, high_reg} + {1'b0, s1};
        s2     = (s2_raw >= FLETCHER_MOD) ? BYTE_W'(s2_raw - FLETCHER_MOD) : s2_raw[BYTE_W-1:0];

        job_next.lead      = opened;
        job_next.trail     = last && !opened && cfg.trail_ok;
        job_next.lead_num  = num_reg;
        job_next.trail_num = num_reg + BYTE_W'(1);
        job_next.lead_len  = len;
        job_next.data      = s_image_byte;
        job_next.eop       = eop;
        job_next.last      = last;
        job_next.sum       = {s2, s1};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taken_reg     <= '0;
            num_reg       <= '0;
            ofs_reg       <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            job_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                job_valid_reg <= 1'b1;
                if (last) begin
                    taken_reg <= '0;
                    num_reg   <= '0;
                    ofs_reg   <= '0;
                    low_reg   <= '0;
                    high_reg  <= '0;
                end else begin
                    taken_reg <= taken_inc[SIZE_W-1:0];
                    low_reg   <= s1;
                    high_reg  <= s2;
                    if (eop) begin
                        ofs_reg <= '0;
                        num_reg <= num_reg + BYTE_W'(1);
                    end else begin
                        ofs_reg <= ofs_inc[OFS_W-1:0];
                    end
                end
            end else if (job_take) begin
                job_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            job_reg <= job_next;
        end
    end

    assign job       = job_reg;
    assign job_valid = job_valid_reg;

    a_ofs_in_chunk: assert property (@(posedge aclk) disable iff (!aresetn)
        ofs_reg < CHUNK_LEN)
        else $error("packet offset beyond chunk");

endmodule

`default_nettype wire

// ===== rtl/upk_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module upk_emit (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire upk_pkg::cfg_t              cfg,
    input  wire upk_pkg::job_t              job,
    input  wire logic                       job_valid,
    output logic                            job_take,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [upk_pkg::BYTE_W-1:0]      m_out_byte,
    output logic                            m_is_header,
    output logic                            m_end_of_packet,
    output logic                            m_last_of_run,
    output logic [upk_pkg::SUM_W-1:0]       m_image_checksum,
    output logic                            m_checksum_valid
);
    import upk_pkg::*;

    logic [BEAT_W-1:0] idx_reg;
    logic [BEAT_W-1:0] idx_next;
    logic              m_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              hdr_reg;
    logic              eop_reg;
    logic              lor_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              csv_reg;

    logic              load;
    logic              is_pay;
    logic              final_beat;
    logic [BEAT_W-1:0] hdr_idx;
    hdr_pos_t          pos;
    logic [BYTE_W-1:0] hdr_num;
    logic [OFS_W-1:0]  hdr_len;
    logic [BYTE_W-1:0] beat_byte;
    logic              beat_eop;

    assign load = job_valid && (!m_valid_reg || m_ready);

    always_comb begin
        is_pay     = job.lead ? (idx_reg == BEAT_FINAL) : (idx_reg == BEAT_FIRST);
        final_beat = (job.lead || job.trail) ? (idx_reg == BEAT_FINAL)
                                             : (idx_reg == BEAT_FIRST);
        hdr_idx    = job.lead ? idx_reg : idx_reg - BEAT_W'(1);
        pos        = hdr_pos_t'(hdr_idx[2:0]);
        hdr_num    = job.lead ? job.lead_num : job.trail_num;
        hdr_len    = job.lead ? job.lead_len : '0;
        beat_byte  = is_pay ? job.data : header_byte(pos, cfg, hdr_num, hdr_len);
        beat_eop   = is_pay ? job.eop : (!job.lead && (pos == POS_LEN_LO));
        job_take   = load && final_beat;
        idx_next   = final_beat ? BEAT_FIRST : idx_reg + BEAT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= BEAT_FIRST;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg     <= idx_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= beat_byte;
            hdr_reg  <= !is_pay;
            eop_reg  <= beat_eop;
            lor_reg  <= final_beat;
            sum_reg  <= job.sum;
            csv_reg  <= is_pay && job.last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_byte       = byte_reg;
    assign m_is_header      = hdr_reg;
    assign m_end_of_packet  = eop_reg;
    assign m_last_of_run    = lor_reg;
    assign m_image_checksum = sum_reg;
    assign m_checksum_valid = csv_reg;

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= BEAT_FINAL)
        else $error("beat index out of range");

    a_take_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        job_take |-> job_valid && load)
        else $error("job released without a beat");

    a_csum_on_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && csv_reg |-> !hdr_reg && eop_reg)
        else $error("final checksum not on a closing payload beat");

    a_empty_hdr_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && hdr_reg && eop_reg |-> lor_reg)
        else $error("header end of packet not last of run");

endmodule

`default_nettype wire

// ===== tb/sv/packet_stream_checker.sv =====
`timescale 1ns / 1ps

module packet_stream_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [upk_pkg::ADDR_W-1:0] paddr,
    input  logic [upk_pkg::DATA_W-1:0] pwdata,
    input  logic [upk_pkg::DATA_W-1:0] prdata,
    input  logic                       pready,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [upk_pkg::BYTE_W-1:0] s_image_byte,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [upk_pkg::BYTE_W-1:0] m_out_byte,
    input  logic                       m_is_header,
    input  logic                       m_end_of_packet,
    input  logic                       m_last_of_run,
    input  logic [upk_pkg::SUM_W-1:0]  m_image_checksum,
    input  logic                       m_checksum_valid,
    output int                         fail_count,
    output int                         pending,
    output int                         beats_seen
);

    localparam int unsigned CHUNK      = upk_pkg::CHUNK_BYTES;

    typedef struct packed {
        logic [7:0]  data;
        logic        hdr;
        logic        eop;
        logic        run_end;
        logic [15:0] sum;
        logic        sum_ok;
    } stream_beat_t;

    logic [7:0]  cfg_start;
    logic [7:0]  cfg_type;
    logic [31:0] cfg_size;

    logic [31:0] taken_count;
    logic [7:0]  pkt_index;
    logic [15:0] pkt_offset;
    logic [7:0]  sum_lo;
    logic [7:0]  sum_hi;

    stream_beat_t run_q[$];
    stream_beat_t beats_due[$];

    initial begin
        fail_count = 0;
        pending    = 0;
        beats_seen = 0;
    end

    task automatic put(input logic [7:0] d, input logic h, input logic e);
        run_q.push_back({d, h, e, 1'b0, 16'd0, 1'b0});
    endtask

    task automatic frame_header(input logic [7:0] num, input logic [15:0] len,
                                input logic empty);
        put(cfg_start, 1'b1, 1'b0);
        put(upk_pkg::SYNC_0, 1'b1, 1'b0);
        put(upk_pkg::SYNC_1, 1'b1, 1'b0);
        put(cfg_type, 1'b1, 1'b0);
        put(upk_pkg::HDR_PAD, 1'b1, 1'b0);
        put(num, 1'b1, 1'b0);
        put(len[15:8], 1'b1, 1'b0);
        put(len[7:0], 1'b1, empty);
    endtask

    // works out every beat that one image byte causes
    task automatic frame_image_byte(input logic [7:0] b);
        logic [31:0] size;
        logic [31:0] remaining;
        logic [31:0] len32;
        logic        last;
        logic        opened;
        logic        eop;
        logic [15:0] sum;
        int          s1;
        int          s2;
        int          pay;
        size   = (cfg_size == 32'd0) ? 32'd1 : cfg_size;
        last   = ({1'b0, taken_count} + 33'd1) >= {1'b0, size};
        opened = 1'b0;
        run_q.delete();
        if (pkt_offset == 16'd0) begin
            remaining = (size > taken_count) ? size - taken_count : 32'd1;
            len32     = (remaining < CHUNK) ? remaining : CHUNK;
            frame_header(pkt_index, len32[15:0], 1'b0);
            opened = 1'b1;
        end
        s1  = (int'(sum_lo) + int'(b)) % 255;
        s2  = (int'(sum_hi) + s1) % 255;
        sum = {s2[7:0], s1[7:0]};
        eop = last || ((int'(pkt_offset) + 1) >= CHUNK);
        pay = run_q.size();
        put(b, 1'b0, eop);
        // image of two or more whole packets gets a bare trailing header
        if (last && !opened && size > CHUNK && (size % CHUNK) == 0)
            frame_header(pkt_index + 8'd1, 16'd0, 1'b1);
        foreach (run_q[k]) run_q[k].sum = sum;
        run_q[pay].sum_ok = last;
        run_q[run_q.size()-1].run_end = 1'b1;
        foreach (run_q[k]) beats_due.push_back(run_q[k]);
        if (last) begin
            taken_count = '0;
            pkt_index   = '0;
            pkt_offset  = '0;
            sum_lo      = '0;
            sum_hi      = '0;
        end else begin
            taken_count = taken_count + 32'd1;
            sum_lo      = s1[7:0];
            sum_hi      = s2[7:0];
            if (eop) begin
                pkt_offset = '0;
                pkt_index  = pkt_index + 8'd1;
            end else begin
                pkt_offset = pkt_offset + 16'd1;
            end
        end
    endtask

    task automatic check_beat();
        stream_beat_t got;
        stream_beat_t want;
        got = {m_out_byte, m_is_header, m_end_of_packet, m_last_of_run,
               m_image_checksum, m_checksum_valid};
        beats_seen++;
        if (beats_due.size() == 0) begin
            fail_count++;
            $display("%0t: expected no beat, got byte %h hdr %b eop %b",
                     $time, got.data, got.hdr, got.eop);
        end else begin
            want = beats_due.pop_front();
            if (got !== want) begin
                fail_count++;
                $display({"%0t: beat mismatch, expected byte %h hdr %b eop %b ",
                          "last %b sum %h valid %b, got byte %h hdr %b eop %b ",
                          "last %b sum %h valid %b"},
                         $time, want.data, want.hdr, want.eop, want.run_end,
                         want.sum, want.sum_ok, got.data, got.hdr, got.eop,
                         got.run_end, got.sum, got.sum_ok);
            end
        end
    endtask

    task automatic check_readback();
        logic [31:0] want;
        logic        known;
        known = 1'b1;
        want  = '0;
        case (paddr[upk_pkg::ADDR_W-1:2])
            upk_pkg::REG_START: want = 32'(cfg_start);
            upk_pkg::REG_TYPE:  want = 32'(cfg_type);
            upk_pkg::REG_SIZE:  want = cfg_size;
            default:            known = 1'b0;
        endcase
        if (known && prdata !== want) begin
            fail_count++;
            $display("%0t: register readback at %h, expected %h actual %h",
                     $time, paddr, want, prdata);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_start   = upk_pkg::START_RESET;
            cfg_type    = upk_pkg::TYPE_RESET;
            cfg_size    = upk_pkg::SIZE_RESET;
            taken_count = '0;
            pkt_index   = '0;
            pkt_offset  = '0;
            sum_lo      = '0;
            sum_hi      = '0;
            beats_due.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[upk_pkg::ADDR_W-1:2])
                        upk_pkg::REG_START: cfg_start = pwdata[7:0];
                        upk_pkg::REG_TYPE:  cfg_type  = pwdata[7:0];
                        upk_pkg::REG_SIZE:  cfg_size  = pwdata[31:0];
                        default: ;
                    endcase
                end else begin
                    check_readback();
                end
            end
            if (s_valid && s_ready) frame_image_byte(s_image_byte);
            if (m_valid && m_ready) check_beat();
        end
        pending = beats_due.size();
    end

endmodule

// ===== tb/sv/tb_update_image_packetizer.sv =====
`timescale 1ns / 1ps

module tb_update_image_packetizer;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 143;
    localparam int TAIL_CYCLES  = 16;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [upk_pkg::ADDR_W-1:0] paddr;
    logic [upk_pkg::DATA_W-1:0] pwdata;
    logic [upk_pkg::DATA_W-1:0] prdata;
    logic                       pready;
    logic                       s_valid;
    logic                       s_ready;
    logic [upk_pkg::BYTE_W-1:0] s_image_byte;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [upk_pkg::BYTE_W-1:0] m_out_byte;
    logic                       m_is_header;
    logic                       m_end_of_packet;
    logic                       m_last_of_run;
    logic [upk_pkg::SUM_W-1:0]  m_image_checksum;
    logic                       m_checksum_valid;

    int fail_count;
    int pending;
    int beats_seen;

    int src_idle     = 13;
    int sink_idle    = 74;
    int cycle_count  = 0;
    int bytes_sent   = 0;
    int images_sent  = 0;
    int reg_writes   = 0;

    always #6 aclk = ~aclk;

    update_image_packetizer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_image_byte     (s_image_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_is_header      (m_is_header),
        .m_end_of_packet  (m_end_of_packet),
        .m_last_of_run    (m_last_of_run),
        .m_image_checksum (m_image_checksum),
        .m_checksum_valid (m_checksum_valid)
    );

    packet_stream_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_image_byte     (s_image_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_is_header      (m_is_header),
        .m_end_of_packet  (m_end_of_packet),
        .m_last_of_run    (m_last_of_run),
        .m_image_checksum (m_image_checksum),
        .m_checksum_valid (m_checksum_valid),
        .fail_count       (fail_count),
        .pending          (pending),
        .beats_seen       (beats_seen)
    );

    always @(negedge aclk) m_ready <= ($urandom_range(99) >= sink_idle);

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d beats outstanding", $time, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(7);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [31:0] eff_size(input logic [31:0] size);
        return (size == 32'd0) ? 32'd1 : size;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_image_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_bytes(input int n);
        repeat (n) send_byte(pick_byte());
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic apb_access(input logic [1:0] idx, input logic wr, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= wr;
        penable <= 1'b0;
        paddr   <= upk_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        apb_access(idx, 1'b1, value);
        reg_writes++;
    endtask

    task automatic read_all_regs();
        apb_access(upk_pkg::REG_START, 1'b0, 32'd0);
        apb_access(upk_pkg::REG_TYPE, 1'b0, 32'd0);
        apb_access(upk_pkg::REG_SIZE, 1'b0, 32'd0);
    endtask

    // feed part of an image, resize it while idle, then finish it
    task automatic resized_image(input logic [31:0] size, input int first_part,
                                 input logic [31:0] new_size);
        logic [31:0] eff;
        wait_drained();
        write_reg(upk_pkg::REG_SIZE, size);
        send_bytes(first_part);
        wait_drained();
        write_reg(upk_pkg::REG_SIZE, new_size);
        eff = eff_size(new_size);
        send_bytes((eff > first_part) ? int'(eff) - first_part : 1);
        images_sent++;
    endtask

    task automatic whole_image(input logic [31:0] size);
        wait_drained();
        write_reg(upk_pkg::REG_SIZE, size);
        send_bytes(int'(eff_size(size)));
        images_sent++;
    endtask

    task automatic random_image();
        logic [31:0] size;
        int          r;
        int          k;
        wait_drained();
        if ($urandom_range(3) == 0) write_reg(upk_pkg::REG_START, 32'(pick_byte()));
        if ($urandom_range(3) == 0) write_reg(upk_pkg::REG_TYPE, 32'(pick_byte()));
        r = $urandom_range(19);
        if (r == 0)      size = 32'd0;
        else if (r == 1) size = 32'd1;
        else             size = 32'($urandom_range(40, 2));
        if (size > 32'd1 && $urandom_range(4) == 0) begin
            k = $urandom_range(int'(size) - 1, 1);
            if ($urandom_range(1) == 0)
                resized_image(size, k, 32'($urandom_range(k, 0)));
            else
                resized_image(size, k, 32'($urandom_range(k + 30, k + 1)));
        end else begin
            whole_image(size);
        end
    endtask

    task automatic directed_part();
        read_all_regs();
        send_byte(8'h00);
        send_byte(8'hFF);
        images_sent += 2;
        wait_drained();
        write_reg(upk_pkg::REG_START, 32'd0);
        write_reg(upk_pkg::REG_TYPE, 32'd0);
        write_reg(upk_pkg::REG_SIZE, 32'd0);
        send_byte(8'hAA);
        images_sent++;
        wait_drained();
        write_reg(upk_pkg::REG_START, 32'd255);
        write_reg(upk_pkg::REG_TYPE, 32'd255);
        write_reg(upk_pkg::REG_SIZE, 32'd3);
        send_byte(8'h55);
        send_byte(8'hFF);
        send_byte(8'h00);
        images_sent++;
        resized_image(32'd10, 4, 32'd2);
        resized_image(32'hFFFF_FFFF, 3, 32'd4);
        wait_drained();
        read_all_regs();
    endtask

    initial begin
        int phase_start;
        aresetn      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_valid      = 1'b0;
        s_image_byte = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        directed_part();
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                src_idle  <= 74;
                sink_idle <= 13;
            end else if (ph == 2) begin
                src_idle  <= 0;
                sink_idle <= 0;
            end
            wait_drained();
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_ITEMS) random_image();
            wait_drained();
            read_all_regs();
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        $display("sent %0d image bytes in %0d images, checked %0d beats, %0d register writes",
                 bytes_sent, images_sent, beats_seen, reg_writes);
        $display("covered size extremes, zero size, resizing mid-image %s",
                 "and register readback under three idle patterns");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
